// ===== rtl/core/cfes_pkg.sv =====
// Shared types and constants of the crash and fault escalation supervisor.
package cfes_pkg;

  localparam int unsigned OP_W       = 3;
  localparam int unsigned MI_W       = 2;
  localparam int unsigned ACT_W      = 3;
  localparam int unsigned CNT_W      = 8;
  localparam int unsigned FL_W       = 2;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned WIN_W      = 22;
  localparam int unsigned TO_W       = 8;
  localparam int unsigned MASK_W     = 4;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 22;
  localparam int unsigned MAX_RESULTS = 4;

  localparam logic [CNT_W-1:0]  CRASH_LIMIT_RST  = 8'd5;
  localparam logic [WIN_W-1:0]  WINDOW_RST       = 22'd7200;
  localparam logic [TO_W-1:0]   HB_TIMEOUT_RST   = 8'd5;
  localparam logic [MASK_W-1:0] SERVICE_MASK_RST = 4'd0;
  localparam logic [FL_W-1:0]   FAULT_STOP_LEVEL = 2'd2;

  typedef enum logic [OP_W-1:0] {
    OP_TICK      = 3'd0,
    OP_START     = 3'd1,
    OP_CONNECT   = 3'd2,
    OP_HEARTBEAT = 3'd3,
    OP_CRASH     = 3'd4
  } op_e;

  typedef enum logic [ACT_W-1:0] {
    ACT_NONE           = 3'd0,
    ACT_RESTART        = 3'd1,
    ACT_FAULT_RESTART  = 3'd2,
    ACT_FAULT_STOP     = 3'd3,
    ACT_WINDOW_CLEARED = 3'd4,
    ACT_REBOOT         = 3'd5
  } action_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CRASH_LIMIT  = 3'd0,
    CFG_WINDOW       = 3'd1,
    CFG_HB_TIMEOUT   = 3'd2,
    CFG_SERVICE_MASK = 3'd3
  } cfg_idx_e;

  typedef struct packed {
    logic load;
    logic mark;
    logic ev_do;
    logic scan_do;
    logic last;
  } cmd_t;

  typedef struct packed {
    logic tick_in;
    logic ev_in;
    logic out_free;
    logic pend_any;
    logic pend_hit;
    logic rest_empty;
  } sts_t;

endpackage

// ===== rtl/core/cfes_if.sv =====
// Valid/ready channel interfaces for input items and result items.
interface cfes_in_if import cfes_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [OP_W-1:0] op;
  logic [MI_W-1:0] module_index;

  modport source (output valid, output op, output module_index, input ready);
  modport sink (input valid, input op, input module_index, output ready);
endinterface

interface cfes_out_if import cfes_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [MI_W-1:0]  module_id;
  logic [ACT_W-1:0] action;
  logic [CNT_W-1:0] crash_count;
  logic [FL_W-1:0]  esc_level;
  logic             last;

  modport source (output valid, output module_id, output action, output crash_count,
                  output esc_level, output last, input ready);
  modport sink (input valid, input module_id, input action, input crash_count,
                input esc_level, input last, output ready);
endinterface

// ===== rtl/core/cfes_ctrl.sv =====
// Controller state machine that sequences events and the per-tick timeout scan.
module cfes_ctrl import cfes_pkg::*; #(
  parameter int unsigned NUM_MODULES = 4,
  parameter int unsigned IW          = 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  sts_t          sts_i,
  output cmd_t          cmd_o,
  output logic [IW-1:0] idx_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MARK,
    ST_SCAN,
    ST_EVENT
  } state_e;

  localparam logic [IW-1:0] IDX_LAST = IW'(NUM_MODULES - 1);
  localparam logic [1:0]    CNT_LAST = 2'(MAX_RESULTS - 1);

  state_e        state_q, state_d;
  logic [IW-1:0] idx_q, idx_d;
  logic [1:0]    cnt_q, cnt_d;
  logic          last_res;

  assign in_ready_o = (state_q == ST_IDLE);
  assign idx_o      = idx_q;
  assign last_res   = sts_i.rest_empty || (cnt_q == CNT_LAST);

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (sts_i.tick_in) begin
            state_d = ST_MARK;
            idx_d   = '0;
          end else if (sts_i.ev_in) begin
            state_d = ST_EVENT;
          end
        end
      end
      ST_MARK: begin
        cmd_o.mark = 1'b1;
        if (idx_q == IDX_LAST) begin
          state_d = ST_SCAN;
          idx_d   = '0;
          cnt_d   = '0;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      ST_SCAN: begin
        if (!sts_i.pend_any) begin
          state_d = ST_IDLE;
        end else if (sts_i.pend_hit) begin
          if (sts_i.out_free) begin
            cmd_o.scan_do = 1'b1;
            cmd_o.last    = last_res;
            cnt_d         = cnt_q + 2'd1;
            if (last_res) begin
              state_d = ST_IDLE;
            end else begin
              idx_d = idx_q + 1'b1;
            end
          end
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      ST_EVENT: begin
        if (sts_i.out_free) begin
          cmd_o.ev_do = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      cnt_q   <= cnt_d;
    end
  end

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.scan_do || cmd_o.ev_do) |-> sts_i.out_free)
    else $error("result loaded while the output register is occupied");

  a_tick_marks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.load && sts_i.tick_in) |=> (state_q == ST_MARK && idx_q == '0))
    else $error("tick did not start the marking pass");

  a_scan_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.scan_do |-> (sts_i.pend_hit && state_q == ST_SCAN))
    else $error("timeout handled for a module that is not pending");

endmodule

// ===== rtl/core/cfes_dp.sv =====
// Datapath with configuration, per-module state, crash handling and result register.
module cfes_dp import cfes_pkg::*; #(
  parameter int unsigned NUM_MODULES = 4,
  parameter int unsigned IW          = 2
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic [OP_W-1:0]       in_op_i,
  input  logic [MI_W-1:0]       in_mi_i,
  input  cmd_t                  cmd_i,
  input  logic [IW-1:0]         idx_i,
  output sts_t                  sts_o,
  input  logic                  out_ready_i,
  output logic                  out_valid_o,
  output logic [MI_W-1:0]       out_module_id_o,
  output logic [ACT_W-1:0]      out_action_o,
  output logic [CNT_W-1:0]      out_crash_count_o,
  output logic [FL_W-1:0]       out_esc_level_o,
  output logic                  out_last_o
);

  localparam logic [4:0] NUM_M = 5'(NUM_MODULES);

  logic [CNT_W-1:0]  lim_q;
  logic [WIN_W-1:0]  win_q;
  logic [TO_W-1:0]   to_q;
  logic [MASK_W-1:0] mask_q;
  logic [TIME_W-1:0] now_q;

  logic [CNT_W-1:0]  cc_q [NUM_MODULES];
  logic [FL_W-1:0]   fl_q [NUM_MODULES];
  logic [TIME_W-1:0] st_q [NUM_MODULES];
  logic [TIME_W-1:0] hb_q [NUM_MODULES];
  logic [NUM_MODULES-1:0] con_q;
  logic [NUM_MODULES-1:0] pend_q;
  logic [NUM_MODULES-1:0] svc_vec;

  logic [OP_W-1:0]  op_q;
  logic [MI_W-1:0]  mi_q;
  logic             out_valid_q;
  logic [MI_W-1:0]  out_mid_q;
  logic [ACT_W-1:0] out_act_q;
  logic [CNT_W-1:0] out_cc_q;
  logic [FL_W-1:0]  out_fl_q;
  logic             out_last_q;

  logic [IW-1:0]    mi_idx;
  logic [IW-1:0]    sel;
  logic [CNT_W-1:0] cc_cur, cc_inc, cr_cc;
  logic [FL_W-1:0]  fl_cur, fl_up, cr_fl;
  action_e          cr_act;
  logic             inwin, in_limit, timed_out, is_crash, do_load;
  logic [NUM_MODULES-1:0] sel_bit;
  logic [MI_W-1:0]  res_mid;
  logic [ACT_W-1:0] res_act;
  logic [CNT_W-1:0] res_cc;
  logic [FL_W-1:0]  res_fl;

  assign mi_idx   = IW'(mi_q);
  assign sel      = cmd_i.ev_do ? mi_idx : idx_i;
  assign sel_bit  = NUM_MODULES'(1) << idx_i;
  assign is_crash = cmd_i.scan_do || (op_q == OP_CRASH);
  assign do_load  = cmd_i.scan_do || cmd_i.ev_do;

  always_comb begin
    for (int i = 0; i < NUM_MODULES; i++) begin
      svc_vec[i] = (i < MASK_W) && mask_q[i % MASK_W];
    end
  end

  always_comb begin
    cc_cur    = cc_q[sel];
    fl_cur    = fl_q[sel];
    cc_inc    = (cc_cur == '1) ? cc_cur : cc_cur + 8'd1;
    inwin     = (now_q - st_q[sel]) <= {{(TIME_W - WIN_W){1'b0}}, win_q};
    in_limit  = (cc_inc <= lim_q);
    fl_up     = (fl_cur < FAULT_STOP_LEVEL) ? fl_cur + 2'd1 : fl_cur;
    timed_out = con_q[idx_i] && ((now_q - hb_q[idx_i]) > {{(TIME_W - TO_W){1'b0}}, to_q});
    cr_cc     = cc_inc;
    cr_fl     = fl_cur;
    cr_act    = ACT_NONE;
    if (svc_vec[sel]) begin
      cr_cc  = cc_cur;
      cr_act = ACT_REBOOT;
    end else if (inwin) begin
      if (in_limit) begin
        cr_act = ACT_RESTART;
      end else begin
        cr_fl  = fl_up;
        cr_cc  = '0;
        cr_act = (fl_up < FAULT_STOP_LEVEL) ? ACT_FAULT_RESTART : ACT_FAULT_STOP;
      end
    end else if (in_limit) begin
      cr_cc  = '0;
      cr_act = ACT_WINDOW_CLEARED;
    end
    res_mid = 2'(sel);
    res_act = is_crash ? cr_act : ACT_NONE;
    res_cc  = is_crash ? cr_cc : cc_cur;
    res_fl  = is_crash ? cr_fl : fl_cur;
  end

  always_comb begin
    sts_o            = '0;
    sts_o.tick_in    = (in_op_i == OP_TICK);
    sts_o.ev_in      = ((in_op_i == OP_START) || (in_op_i == OP_CONNECT) ||
                        (in_op_i == OP_HEARTBEAT) || (in_op_i == OP_CRASH)) &&
                       ({3'b000, in_mi_i} < NUM_M);
    sts_o.out_free   = !out_valid_q || out_ready_i;
    sts_o.pend_any   = |pend_q;
    sts_o.pend_hit   = pend_q[idx_i];
    sts_o.rest_empty = ((pend_q & ~sel_bit) == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lim_q       <= CRASH_LIMIT_RST;
      win_q       <= WINDOW_RST;
      to_q        <= HB_TIMEOUT_RST;
      mask_q      <= SERVICE_MASK_RST;
      now_q       <= '0;
      con_q       <= '0;
      pend_q      <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NUM_MODULES; i++) begin
        cc_q[i] <= '0;
        fl_q[i] <= '0;
        st_q[i] <= '0;
        hb_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_CRASH_LIMIT:  lim_q  <= cfg_wdata_i[CNT_W-1:0];
          CFG_WINDOW:       win_q  <= cfg_wdata_i[WIN_W-1:0];
          CFG_HB_TIMEOUT:   to_q   <= cfg_wdata_i[TO_W-1:0];
          CFG_SERVICE_MASK: mask_q <= cfg_wdata_i[MASK_W-1:0];
          default: begin
          end
        endcase
      end
      if (cmd_i.load && (in_op_i == OP_TICK)) begin
        now_q <= now_q + 32'd1;
      end
      if (cmd_i.mark) begin
        pend_q[idx_i] <= timed_out;
      end
      if (cmd_i.scan_do) begin
        pend_q[idx_i] <= 1'b0;
        con_q[sel]    <= 1'b0;
        cc_q[sel]     <= cr_cc;
        fl_q[sel]     <= cr_fl;
      end
      if (cmd_i.ev_do) begin
        case (op_e'(op_q))
          OP_START: begin
            st_q[sel] <= now_q;
          end
          OP_CONNECT: begin
            con_q[sel] <= 1'b1;
            hb_q[sel]  <= now_q;
          end
          OP_HEARTBEAT: begin
            if (con_q[sel]) begin
              hb_q[sel] <= now_q;
            end
          end
          OP_CRASH: begin
            con_q[sel] <= 1'b0;
            cc_q[sel]  <= cr_cc;
            fl_q[sel]  <= cr_fl;
          end
          default: begin
          end
        endcase
      end
      if (do_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q <= in_op_i;
      mi_q <= in_mi_i;
    end
    if (do_load) begin
      out_mid_q  <= res_mid;
      out_act_q  <= res_act;
      out_cc_q   <= res_cc;
      out_fl_q   <= res_fl;
      out_last_q <= cmd_i.ev_do || cmd_i.last;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign out_module_id_o   = out_mid_q;
  assign out_action_o      = out_act_q;
  assign out_crash_count_o = out_cc_q;
  assign out_esc_level_o   = out_fl_q;
  assign out_last_o        = out_last_q;

  a_level_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_fl_q != 2'd3))
    else $error("fault level above the stop level");

  a_fault_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && ((out_act_q == ACT_FAULT_RESTART) || (out_act_q == ACT_FAULT_STOP)))
      |-> (out_cc_q == '0))
    else $error("fault escalation left a nonzero crash count");

endmodule

// ===== rtl/core/crash_fault_escalation_supervisor.sv =====
// An event item gives its one result, loaded into the output register from the event state
// once that register is free. A tick passes the marking state, one module at a time, then
// the scan state, which handles each pending timeout through the single shared compare unit.
// A new item is taken only in the idle state, after the previous item is through.
// A stalled output register holds the scan until the pending result is taken.
// Reset clears the seconds counter, all per-module state and restores register defaults.
module crash_fault_escalation_supervisor import cfes_pkg::*; #(
  parameter int unsigned NUM_MODULES = 4
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  cfes_in_if.sink               in_if,
  cfes_out_if.source            out_if
);

  localparam int unsigned IW = (NUM_MODULES > 1) ? $clog2(NUM_MODULES) : 1;

  cmd_t          cmd;
  sts_t          sts;
  logic [IW-1:0] idx;

  cfes_ctrl #(
    .NUM_MODULES (NUM_MODULES),
    .IW          (IW)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_if.valid),
    .in_ready_o (in_if.ready),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .idx_o      (idx)
  );

  cfes_dp #(
    .NUM_MODULES (NUM_MODULES),
    .IW          (IW)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_op_i           (in_if.op),
    .in_mi_i           (in_if.module_index),
    .cmd_i             (cmd),
    .idx_i             (idx),
    .sts_o             (sts),
    .out_ready_i       (out_if.ready),
    .out_valid_o       (out_if.valid),
    .out_module_id_o   (out_if.module_id),
    .out_action_o      (out_if.action),
    .out_crash_count_o (out_if.crash_count),
    .out_esc_level_o   (out_if.esc_level),
    .out_last_o        (out_if.last)
  );

endmodule

// ===== sim/tb_crash_fault_escalation_supervisor.sv =====
// Testbench for the crash and fault escalation supervisor with directed and random items.
`timescale 1ns / 100ps

module tb_crash_fault_escalation_supervisor;
  import cfes_pkg::*;

  localparam int unsigned MODULES       = 4;
  localparam int unsigned CLK_PERIOD    = 12;
  localparam int unsigned RESET_CYCLES  = 9;
  localparam int unsigned SETTLE_CYCLES = 4 * (2 + 2 * MODULES);
  localparam int unsigned PHASES        = 6;
  localparam int unsigned PHASE_ITEMS   = 25;
  localparam int unsigned SAT_CRASHES   = 260;
  localparam int unsigned NUM_CFG_REGS  = 4;
  localparam int unsigned TIMEOUT_NS    = 10_000_000;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic [MI_W-1:0] mi;
  } sup_event_t;

  typedef struct packed {
    logic [MI_W-1:0]  module_id;
    action_e          action;
    logic [CNT_W-1:0] crash_count;
    logic [FL_W-1:0]  esc_level;
    logic             last;
  } outcome_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  cfes_in_if  in_if ();
  cfes_out_if out_if ();

  crash_fault_escalation_supervisor #(
    .NUM_MODULES(MODULES)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_if      (in_if),
    .out_if     (out_if)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  sup_event_t  event_queue[$];
  outcome_t    pending_results[$];
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned error_count = 0;

  logic [CNT_W-1:0]    crash_limit_q;
  logic [WIN_W-1:0]    window_q;
  logic [TO_W-1:0]     hb_timeout_q;
  logic [MASK_W-1:0]   service_mask_q;
  logic [TIME_W-1:0]   now_sec;
  logic [CNT_W-1:0]    crash_tally [MODULES];
  logic [FL_W-1:0]     fault_lvl [MODULES];
  logic [TIME_W-1:0]   start_sec [MODULES];
  logic [TIME_W-1:0]   beat_sec  [MODULES];
  logic                online    [MODULES];

  task automatic report_mismatch(input string msg);
    error_count++;
    $display("MISMATCH at %0t ns: %s", $time, msg);
  endtask

  function automatic action_e crash_verdict(input int unsigned m);
    logic [TIME_W-1:0] elapsed;
    if (service_mask_q[m]) begin
      return ACT_REBOOT;
    end
    if (crash_tally[m] != {CNT_W{1'b1}}) begin
      crash_tally[m] = crash_tally[m] + 1'b1;
    end
    elapsed = now_sec - start_sec[m];
    if (elapsed <= TIME_W'(window_q)) begin
      if (crash_tally[m] <= crash_limit_q) begin
        return ACT_RESTART;
      end
      if (fault_lvl[m] < FAULT_STOP_LEVEL) begin
        fault_lvl[m] = fault_lvl[m] + 1'b1;
      end
      crash_tally[m] = '0;
      return (fault_lvl[m] < FAULT_STOP_LEVEL) ? ACT_FAULT_RESTART : ACT_FAULT_STOP;
    end
    if (crash_tally[m] <= crash_limit_q) begin
      crash_tally[m] = '0;
      return ACT_WINDOW_CLEARED;
    end
    return ACT_NONE;
  endfunction

  function automatic outcome_t snapshot(input int unsigned m, input action_e act);
    outcome_t res;
    res.module_id   = MI_W'(m);
    res.action      = act;
    res.crash_count = crash_tally[m];
    res.esc_level   = fault_lvl[m];
    res.last        = 1'b0;
    return res;
  endfunction

  task automatic supervise_event(input sup_event_t ev);
    outcome_t          burst[$];
    outcome_t          res;
    action_e           act;
    logic [TIME_W-1:0] silent;
    int unsigned       m;
    m   = ev.mi;
    act = ACT_NONE;
    if (ev.op == OP_TICK) begin
      now_sec = now_sec + 1'b1;
      for (int i = 0; i < MODULES; i++) begin
        silent = now_sec - beat_sec[i];
        if (online[i] && silent > TIME_W'(hb_timeout_q)) begin
          online[i] = 1'b0;
          act = crash_verdict(i);
          burst.push_back(snapshot(i, act));
        end
      end
      if (burst.size() != 0) begin
        burst[burst.size() - 1].last = 1'b1;
      end
      foreach (burst[k]) pending_results.push_back(burst[k]);
      return;
    end
    case (ev.op)
      OP_START: begin
        start_sec[m] = now_sec;
      end
      OP_CONNECT: begin
        online[m]   = 1'b1;
        beat_sec[m] = now_sec;
      end
      OP_HEARTBEAT: begin
        if (online[m]) begin
          beat_sec[m] = now_sec;
        end
      end
      OP_CRASH: begin
        online[m] = 1'b0;
        act = crash_verdict(m);
      end
      default: begin
        return;
      end
    endcase
    res = snapshot(m, act);
    res.last = 1'b1;
    pending_results.push_back(res);
  endtask

  task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    end
  endtask

  // Input driver: presents queued items, holds them until taken.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_if.valid        <= 1'b0;
      in_if.op           <= '0;
      in_if.module_index <= '0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        supervise_event(event_queue.pop_front());
      end
      if (!in_if.valid || in_if.ready) begin
        if (event_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_if.valid        <= 1'b1;
          in_if.op           <= event_queue[0].op;
          in_if.module_index <= event_queue[0].mi;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compares each taken item with the oldest expected result.
  always @(posedge clk_i) begin
    outcome_t want;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result for module %0d action %0d",
                                    out_if.module_id, out_if.action));
        end else begin
          want = pending_results.pop_front();
          check_field("module_id", out_if.module_id, want.module_id);
          check_field("action", out_if.action, want.action);
          check_field("crash_count", out_if.crash_count, want.crash_count);
          check_field("esc_level", out_if.esc_level, want.esc_level);
          check_field("last", out_if.last, want.last);
        end
      end
      out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic push_event(input logic [OP_W-1:0] op, input int unsigned mi);
    sup_event_t ev;
    ev.op = op;
    ev.mi = MI_W'(mi);
    event_queue.push_back(ev);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    case (idx)
      CFG_CRASH_LIMIT:  crash_limit_q  = data[CNT_W-1:0];
      CFG_WINDOW:       window_q       = data[WIN_W-1:0];
      CFG_HB_TIMEOUT:   hb_timeout_q   = data[TO_W-1:0];
      CFG_SERVICE_MASK: service_mask_q = data[MASK_W-1:0];
      default: ;
    endcase
  endtask

  // Upper data bits above each register's width are filled with noise.
  task automatic configure(input logic [CNT_W-1:0] limit, input logic [WIN_W-1:0] window,
                           input logic [TO_W-1:0] timeout, input logic [MASK_W-1:0] mask);
    logic [CFG_DATA_W-1:0] noise;
    noise = CFG_DATA_W'($urandom);
    write_reg(CFG_CRASH_LIMIT, {noise[CFG_DATA_W-1:CNT_W], limit});
    write_reg(CFG_WINDOW, window);
    write_reg(CFG_HB_TIMEOUT, {noise[CFG_DATA_W-1:TO_W], timeout});
    write_reg(CFG_SERVICE_MASK, {noise[CFG_DATA_W-1:MASK_W], mask});
    write_reg(CFG_IDX_W'($urandom_range(NUM_CFG_REGS, 2 ** CFG_IDX_W - 1)),
              CFG_DATA_W'($urandom));
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic queue_random_events(input int unsigned count);
    int unsigned taken;
    int unsigned pick;
    int unsigned mi;
    taken = 0;
    while (taken < count) begin
      pick = $urandom_range(99);
      mi   = $urandom_range(0, MODULES - 1);
      taken++;
      if (pick < 35) begin
        push_event(OP_TICK, mi);
      end else if (pick < 45) begin
        push_event(OP_START, mi);
      end else if (pick < 60) begin
        push_event(OP_CONNECT, mi);
      end else if (pick < 80) begin
        push_event(OP_HEARTBEAT, mi);
      end else if (pick < 96) begin
        push_event(OP_CRASH, mi);
      end else begin
        push_event(OP_W'($urandom_range(OP_CRASH + 1, 2 ** OP_W - 1)), mi);
        taken--;
      end
    end
  endtask

  task automatic wait_drained();
    do begin
      @(posedge clk_i);
    end while (event_queue.size() != 0 || pending_results.size() != 0 || in_if.valid);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    int unsigned target;
    rst_ni             = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_idx_i          = '0;
    cfg_wdata_i        = '0;
    send_idle_pct      = 13;
    recv_idle_pct      = 75;
    crash_limit_q      = CRASH_LIMIT_RST;
    window_q           = WINDOW_RST;
    hb_timeout_q       = HB_TIMEOUT_RST;
    service_mask_q     = SERVICE_MASK_RST;
    now_sec            = '0;
    for (int i = 0; i < MODULES; i++) begin
      crash_tally[i] = '0;
      fault_lvl[i]   = '0;
      start_sec[i]   = '0;
      beat_sec[i]    = '0;
      online[i]      = 1'b0;
    end
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Heartbeat before connect, crash of connected and unconnected module,
    // undefined ops, then ticks until every module times out on the last one.
    push_event(OP_HEARTBEAT, 2);
    push_event(OP_START, 0);
    push_event(OP_START, MODULES - 1);
    for (int i = 0; i < MODULES; i++) push_event(OP_CONNECT, i);
    push_event(OP_CRASH, MODULES - 1);
    push_event(OP_CRASH, MODULES - 1);
    push_event(OP_CONNECT, MODULES - 1);
    push_event(OP_HEARTBEAT, 1);
    for (int k = OP_CRASH + 1; k < 2 ** OP_W; k++) push_event(OP_W'(k), MODULES - 1);
    repeat (HB_TIMEOUT_RST + 1) push_event(OP_TICK, 0);
    wait_drained();

    for (int p = 0; p < PHASES; p++) begin
      if (p == 2) begin
        send_idle_pct = 75;
        recv_idle_pct = 13;
      end else if (p == 4) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (p)
        0: configure('0, {WIN_W{1'b1}}, TO_W'(1), '0);
        1: configure({CNT_W{1'b1}}, '0, {TO_W{1'b1}}, '0);
        2: configure(CNT_W'(1), WIN_W'(12), TO_W'(2), MASK_W'(4'b1010));
        3: configure(CNT_W'($urandom_range(0, 3)), WIN_W'($urandom_range(0, 30)),
                     TO_W'($urandom_range(1, 6)), {MASK_W{1'b1}});
        default: configure(CNT_W'($urandom_range(0, 3)), WIN_W'($urandom_range(0, 30)),
                           TO_W'($urandom_range(1, 6)), MASK_W'($urandom_range(0, 15)));
      endcase
      queue_random_events(PHASE_ITEMS);
      wait_drained();
    end

    // With no window and no allowance, crashes outside the window keep
    // counting until the count saturates.
    configure('0, '0, {TO_W{1'b1}}, '0);
    target = $urandom_range(0, MODULES - 1);
    push_event(OP_TICK, 0);
    repeat (SAT_CRASHES) push_event(OP_CRASH, target);
    wait_drained();

    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/cfes_pkg.sv
rtl/core/cfes_if.sv
rtl/core/cfes_ctrl.sv
rtl/core/cfes_dp.sv
rtl/core/crash_fault_escalation_supervisor.sv
sim/tb_crash_fault_escalation_supervisor.sv
